// ----- hw/rtl/pol_pkg.sv -----
package pol_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 16;
    localparam int VALUE_W             = 32;
    localparam int POS_W               = 8;
    localparam int TOTAL_W             = 5;
    // Wide enough to index the largest supported row of cells.
    localparam int CELL_IDX_W          = 6;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_POS   = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]            op;
        logic [CELL_IDX_W-1:0] sel_idx;
        logic [CELL_IDX_W-1:0] tail_idx;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/pol_cell.sv -----
module pol_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  pol_pkg::cell_ctl_t            ctl,
    input  logic [pol_pkg::VALUE_W-1:0]   left_value,
    input  logic [pol_pkg::VALUE_W-1:0]   right_value,
    input  logic [pol_pkg::VALUE_W-1:0]   head_value,
    input  logic [pol_pkg::VALUE_W-1:0]   new_value,
    output logic [pol_pkg::VALUE_W-1:0]   value
);
    import pol_pkg::*;

    localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(CELL_IDX);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.op)
            CELL_INSERT:
            begin
                // Cells past the insertion point take their left neighbor.
                if (MY_IDX > ctl.sel_idx)
                    value_next = left_value;
                else if (MY_IDX == ctl.sel_idx)
                    value_next = new_value;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= ctl.sel_idx)
                    value_next = right_value;
            end
            CELL_ROTATE:
            begin
                // The tail cell wraps the head around so the list is restored
                // after a full pass.
                if (MY_IDX == ctl.tail_idx)
                    value_next = head_value;
                else
                    value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- hw/rtl/positional_ordered_list.sv -----
// Insert and delete: the cells change at the accepting edge; the result is presented
// the cycle after the input is accepted, one transaction per cycle unless the output
// stalls. Listing: the block enters its list state, then values leave cell 0, one per
// cycle unless the output stalls, as the row rotates its head through cell 0; the next
// input can be taken at the edge that hands off the last one. Reset clears the entry
// count and all handshake state; cell contents are undefined until written.
module positional_ordered_list #(
    parameter int MAX_ENTRIES = pol_pkg::MAX_ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], item_value[39:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[31:0], entry_total[36:32], zero[39:37]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import pol_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       remain_reg, remain_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic [1:0]          status_reg, status_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                last_reg, last_next;

    logic [VALUE_W-1:0]  cell_value [MAX_ENTRIES];
    cell_ctl_t           cell_ctl;

    logic [1:0]          cmd;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  item_value;
    logic [POS_W-1:0]    pos_m1;
    logic [IW-1:0]       sel_idx;
    logic [CW-1:0]       count_m1;
    logic [IW-1:0]       tail_idx;
    logic [POS_W:0]      pos_ext;
    logic [POS_W:0]      count_ext;
    logic                out_free;
    logic                accept;
    logic                list_full;

    assign cmd        = s_tuser;
    assign position   = s_tdata[7:0];
    assign item_value = s_tdata[39:8];

    assign pos_m1    = position - 8'd1;
    assign sel_idx   = pos_m1[IW-1:0];
    assign count_m1  = count_reg - 1'b1;
    assign tail_idx  = count_m1[IW-1:0];
    assign pos_ext   = {1'b0, position};
    assign count_ext = (POS_W + 1)'(count_reg);
    assign list_full = (count_reg == CW'(MAX_ENTRIES));

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        cell_ctl.op       = CELL_HOLD;
        cell_ctl.sel_idx  = CELL_IDX_W'(sel_idx);
        cell_ctl.tail_idx = CELL_IDX_W'(tail_idx);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_value_next = '0;
                    status_next    = STATUS_OK;
                    total_next     = TOTAL_W'(count_reg);
                    last_next      = 1'b1;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            m_valid_next = 1'b1;
                            if (list_full)
                                status_next = STATUS_FULL;
                            else if (position == '0 || pos_ext > count_ext + 1'b1)
                                status_next = STATUS_BAD_POS;
                            else
                            begin
                                cell_ctl.op = CELL_INSERT;
                                count_next  = count_reg + 1'b1;
                                total_next  = TOTAL_W'(count_reg + 1'b1);
                            end
                        end
                        CMD_DELETE:
                        begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0)
                                status_next = STATUS_EMPTY;
                            else if (position == '0 || pos_ext > count_ext)
                                status_next = STATUS_BAD_POS;
                            else
                            begin
                                cell_ctl.op    = CELL_DELETE;
                                out_value_next = cell_value[sel_idx];
                                count_next     = count_m1;
                                total_next     = TOTAL_W'(count_m1);
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                m_valid_next = 1'b1;
                                status_next  = STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next  = ST_LIST;
                                remain_next = count_reg;
                            end
                        end
                        default:
                        begin
                            // The unused command produces no result.
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (out_free)
                begin
                    cell_ctl.op    = CELL_ROTATE;
                    m_valid_next   = 1'b1;
                    out_value_next = cell_value[0];
                    status_next    = STATUS_OK;
                    total_next     = TOTAL_W'(count_reg);
                    last_next      = (remain_reg == CW'(1));
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        total_reg     <= total_next;
        last_reg      <= last_next;
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [VALUE_W-1:0] left_value;
        logic [VALUE_W-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_end
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        pol_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .left_value  (left_value),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .new_value   (item_value),
            .value       (cell_value[i])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, total_reg, out_value_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule
